[hdl/sms_pkg.sv]
// Shared types, constants and codes for the sorted counted multiset.
package sms_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 16;
    localparam int KEY_W       = 16;
    localparam int COUNT_BITS  = 16;
    localparam int USED_W      = 7;
    localparam int STATUS_W    = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [USED_W-1:0]     USED_FULL = USED_W'(TABLE_DEPTH);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_RAISED    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOWERED   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RAISE,
        OP_LOWER,
        OP_DELETE,
        OP_INSERT
    } op_t;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [COUNT_BITS-1:0] count_after;
        logic [USED_W-1:0]     entries_used;
    } out_item_t;

    typedef struct packed {
        logic                cmp_en;
        logic                upd_en;
        op_t                 op;
        logic [KEY_BITS-1:0] key;
    } cell_ctrl_t;

endpackage

[hdl/sms_cell.sv]
// One slot of the sorted table: key, count, compare flags and neighbor shift.
module sms_cell (
    input  logic                            aclk,
    input  sms_pkg::cell_ctrl_t             ctrl,
    input  logic                            slot_valid,
    input  logic                            slot_at_used,
    input  logic                            below_gt,
    input  logic [sms_pkg::KEY_BITS-1:0]    below_key,
    input  logic [sms_pkg::COUNT_BITS-1:0]  below_count,
    input  logic [sms_pkg::KEY_BITS-1:0]    above_key,
    input  logic [sms_pkg::COUNT_BITS-1:0]  above_count,
    output logic [sms_pkg::KEY_BITS-1:0]    key,
    output logic [sms_pkg::COUNT_BITS-1:0]  count,
    output logic                            gt,
    output logic                            match,
    output logic [sms_pkg::COUNT_BITS-1:0]  match_count
);

    logic [sms_pkg::KEY_BITS-1:0]   key_reg;
    logic [sms_pkg::KEY_BITS-1:0]   key_next;
    logic [sms_pkg::COUNT_BITS-1:0] count_reg;
    logic [sms_pkg::COUNT_BITS-1:0] count_next;
    logic                           match_reg;
    logic                           match_next;
    logic                           gt_reg;
    logic                           gt_next;

    always_comb begin
        match_next = match_reg;
        gt_next    = gt_reg;
        if (ctrl.cmp_en) begin
            match_next = slot_valid && (key_reg == ctrl.key);
            gt_next    = slot_valid && (key_reg > ctrl.key);
        end
    end

    always_comb begin
        key_next   = key_reg;
        count_next = count_reg;
        if (ctrl.upd_en) begin
            case (ctrl.op)
                sms_pkg::OP_RAISE: begin
                    if (match_reg && (count_reg != sms_pkg::COUNT_MAX)) begin
                        count_next = count_reg + sms_pkg::COUNT_ONE;
                    end
                end
                sms_pkg::OP_LOWER: begin
                    if (match_reg) begin
                        count_next = count_reg - sms_pkg::COUNT_ONE;
                    end
                end
                sms_pkg::OP_DELETE: begin
                    if (match_reg || gt_reg) begin
                        key_next   = above_key;
                        count_next = above_count;
                    end
                end
                sms_pkg::OP_INSERT: begin
                    if (below_gt) begin
                        key_next   = below_key;
                        count_next = below_count;
                    end else if (gt_reg || slot_at_used) begin
                        key_next   = ctrl.key;
                        count_next = sms_pkg::COUNT_ONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        count_reg <= count_next;
        match_reg <= match_next;
        gt_reg    <= gt_next;
    end

    assign key         = key_reg;
    assign count       = count_reg;
    assign gt          = gt_reg;
    assign match       = match_reg;
    assign match_count = match_reg ? count_reg : '0;

endmodule

[hdl/sorted_counted_multiset_top.sv]
// Top level of the sorted counted multiset: control, cell row and result register.
// Each transfer runs through a compare state and an update state: in the compare
// state, every cell compares its key with the item's key in parallel; in the update
// state, the row raises, lowers, inserts or deletes in one parallel shift and the
// result is loaded into the output register. A new item is taken in the update
// state of the previous one, so back-to-back items skip the idle state; the
// update, and with it the next transfer, waits while an earlier result is still held
// in the output register. No clearing pass follows reset.
module sorted_counted_multiset_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sms_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sms_pkg::out_item_t  m_data
);

    localparam int N = sms_pkg::TABLE_DEPTH;

    sms_pkg::state_t    state_reg;
    sms_pkg::state_t    state_next;
    sms_pkg::in_item_t  item_reg;
    logic [sms_pkg::USED_W-1:0] used_reg;
    logic [sms_pkg::USED_W-1:0] used_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    sms_pkg::out_item_t m_data_reg;

    logic               out_free;
    logic               cmp_en;
    logic               commit;
    sms_pkg::op_t       op;
    sms_pkg::out_item_t result;
    sms_pkg::cell_ctrl_t ctrl;

    logic [sms_pkg::KEY_BITS-1:0]   cell_key   [N];
    logic [sms_pkg::COUNT_BITS-1:0] cell_count [N];
    logic [sms_pkg::COUNT_BITS-1:0] cell_mcnt  [N];
    logic [N-1:0]                   cell_gt;
    logic [N-1:0]                   cell_match;
    logic [sms_pkg::COUNT_BITS-1:0] match_count;
    logic                           any_match;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sms_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sms_pkg::ST_CMP;
                end
            end
            sms_pkg::ST_CMP: begin
                state_next = sms_pkg::ST_UPD;
            end
            sms_pkg::ST_UPD: begin
                if (out_free) begin
                    state_next = s_valid ? sms_pkg::ST_CMP : sms_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sms_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmp_en  = 1'b0;
        commit  = 1'b0;
        case (state_reg)
            sms_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            sms_pkg::ST_CMP: begin
                cmp_en = 1'b1;
            end
            sms_pkg::ST_UPD: begin
                s_ready = out_free;
                commit  = out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        match_count = '0;
        for (int i = 0; i < N; i++) begin
            match_count = match_count | cell_mcnt[i];
        end
    end

    assign any_match = |cell_match;

    always_comb begin
        op                  = sms_pkg::OP_NONE;
        result.status       = sms_pkg::STATUS_NOT_FOUND;
        result.count_after  = '0;
        used_next           = used_reg;
        if (item_reg.kind == sms_pkg::KIND_INSERT) begin
            if (any_match) begin
                op                 = sms_pkg::OP_RAISE;
                result.status      = sms_pkg::STATUS_RAISED;
                result.count_after = (match_count == sms_pkg::COUNT_MAX) ?
                                     match_count : match_count + sms_pkg::COUNT_ONE;
            end else if (used_reg == sms_pkg::USED_FULL) begin
                result.status = sms_pkg::STATUS_FULL;
            end else begin
                op                 = sms_pkg::OP_INSERT;
                result.status      = sms_pkg::STATUS_ADDED;
                result.count_after = sms_pkg::COUNT_ONE;
                used_next          = used_reg + sms_pkg::USED_W'(1);
            end
        end else begin
            if (!any_match) begin
                result.status = sms_pkg::STATUS_NOT_FOUND;
            end else if (match_count > sms_pkg::COUNT_ONE) begin
                op                 = sms_pkg::OP_LOWER;
                result.status      = sms_pkg::STATUS_LOWERED;
                result.count_after = match_count - sms_pkg::COUNT_ONE;
            end else begin
                op            = sms_pkg::OP_DELETE;
                result.status = sms_pkg::STATUS_DELETED;
                used_next     = used_reg - sms_pkg::USED_W'(1);
            end
        end
        result.entries_used = used_next;
    end

    assign ctrl.cmp_en = cmp_en;
    assign ctrl.upd_en = commit;
    assign ctrl.op     = op;
    assign ctrl.key    = item_reg.key[sms_pkg::KEY_BITS-1:0];

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic                           below_gt;
        logic [sms_pkg::KEY_BITS-1:0]   below_key;
        logic [sms_pkg::COUNT_BITS-1:0] below_count;
        logic [sms_pkg::KEY_BITS-1:0]   above_key;
        logic [sms_pkg::COUNT_BITS-1:0] above_count;

        if (g == 0) begin : g_first
            assign below_gt    = 1'b0;
            assign below_key   = cell_key[g];
            assign below_count = cell_count[g];
        end else begin : g_mid
            assign below_gt    = cell_gt[g-1];
            assign below_key   = cell_key[g-1];
            assign below_count = cell_count[g-1];
        end

        if (g == N - 1) begin : g_last
            assign above_key   = cell_key[g];
            assign above_count = cell_count[g];
        end else begin : g_top
            assign above_key   = cell_key[g+1];
            assign above_count = cell_count[g+1];
        end

        sms_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .slot_valid  (sms_pkg::USED_W'(g) < used_reg),
            .slot_at_used(sms_pkg::USED_W'(g) == used_reg),
            .below_gt    (below_gt),
            .below_key   (below_key),
            .below_count (below_count),
            .above_key   (above_key),
            .above_count (above_count),
            .key         (cell_key[g]),
            .count       (cell_count[g]),
            .gt          (cell_gt[g]),
            .match       (cell_match[g]),
            .match_count (cell_mcnt[g])
        );
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sms_pkg::ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                used_reg <= used_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (commit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= sms_pkg::USED_FULL)
        else $error("entry count above table depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == sms_pkg::ST_CMP))
        else $error("accepted transfer did not start compare");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (op == sms_pkg::OP_INSERT)) |=>
        (used_reg == $past(used_reg) + sms_pkg::USED_W'(1)))
        else $error("insert did not grow the table");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sms_pkg::ST_UPD) |-> $onehot0(cell_match))
        else $error("key matched in more than one slot");

endmodule
